// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the edit distance block checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define UED_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, checked on every rising edge outside reset
`define UED_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== hdl/ued_pkg.sv =====
// ----------------------------------------------------------------------------
// ued_pkg
// types, sizes and helpers shared by the utf-8 edit distance block
// ----------------------------------------------------------------------------
package ued_pkg;

  localparam int MAX_CHARS = 32;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);
  localparam int ADDR_W    = $clog2(MAX_CHARS);
  localparam int DIST_W    = 6;
  localparam int GRP_W     = 3;
  localparam int BYTES_MAX = 7;
  localparam int ASM_W     = 8 * (BYTES_MAX - 1) + 8;
  localparam int KEY_W     = ASM_W + GRP_W;

  typedef struct packed {
    logic       command;
    logic [7:0] in_byte;
    logic       end_of_word;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } out_word_t;

  // character key: group length on top, bytes below (byte k at bit 8k)
  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic done;
    key_t key;
  } char_evt_t;

  typedef struct packed {
    logic              init;
    logic              setup;
    logic              step;
    logic [ADDR_W-1:0] idx;
  } dp_ctrl_t;

  // bytes in a character: one, plus one per leading one bit below bit 7
  function automatic logic [GRP_W-1:0] group_len(input logic [7:0] b);
    logic [GRP_W-1:0] n;
    logic             run;
    n   = GRP_W'(1);
    run = b[7];
    for (int k = 6; k >= 1; k--) begin
      if (run && b[k]) begin
        n = n + GRP_W'(1);
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

endpackage

// ===== hdl/ued_char_asm.sv =====
// ----------------------------------------------------------------------------
// ued_char_asm
// groups incoming bytes into characters and builds the compare key
// ----------------------------------------------------------------------------
module ued_char_asm (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              opening,
  input  logic [7:0]        in_byte,
  input  logic              eow,
  output ued_pkg::char_evt_t evt
);
  import ued_pkg::*;

  logic [ASM_W-1:0] asm_bytes;
  logic [GRP_W-1:0] byte_cnt;
  logic [GRP_W-1:0] bytes_left;

  logic [ASM_W-1:0] asm_cur, asm_next;
  logic [GRP_W-1:0] cnt_cur, cnt_next;
  logic [GRP_W-1:0] left_cur, left_next;
  logic             fin;

  always_comb begin
    // a new word drops any partial group
    asm_cur  = opening ? '0 : asm_bytes;
    cnt_cur  = opening ? '0 : byte_cnt;
    left_cur = opening ? '0 : bytes_left;
    if (left_cur == '0) begin
      asm_next  = ASM_W'(in_byte);
      cnt_next  = GRP_W'(1);
      left_next = group_len(in_byte) - GRP_W'(1);
    end else begin
      asm_next = asm_cur;
      for (int k = 0; k < BYTES_MAX; k++) begin
        if (cnt_cur == GRP_W'(k)) begin
          asm_next[8*k +: 8] = in_byte;
        end
      end
      cnt_next  = cnt_cur + GRP_W'(1);
      left_next = left_cur - GRP_W'(1);
    end
    // end of word closes a short group too
    fin       = (left_next == '0) || eow;
    evt.done  = accept && fin;
    evt.key   = {cnt_next, asm_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      asm_bytes  <= '0;
      byte_cnt   <= '0;
      bytes_left <= '0;
    end else if (accept) begin
      if (fin) begin
        asm_bytes  <= '0;
        byte_cnt   <= '0;
        bytes_left <= '0;
      end else begin
        asm_bytes  <= asm_next;
        byte_cnt   <= cnt_next;
        bytes_left <= left_next;
      end
    end
  end

endmodule

// ===== hdl/ued_query_mem.sv =====
// ----------------------------------------------------------------------------
// ued_query_mem
// character store of the query word, one write and one registered read port
// ----------------------------------------------------------------------------
module ued_query_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ued_pkg::ADDR_W-1:0] waddr,
  input  ued_pkg::key_t              wdata,
  input  logic [ued_pkg::ADDR_W-1:0] raddr,
  output ued_pkg::key_t              rdata
);
  import ued_pkg::*;

  key_t mem [MAX_CHARS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ued_dp_row.sv =====
// ----------------------------------------------------------------------------
// ued_dp_row
// dynamic programming row and the shared cell update unit
// ----------------------------------------------------------------------------
module ued_dp_row (
  input  logic                       clk,
  input  ued_pkg::dp_ctrl_t          ctrl,
  input  ued_pkg::key_t              key,
  input  ued_pkg::key_t              qchar,
  input  logic                       rd_zero,
  output logic [ued_pkg::DIST_W-1:0] rd_dist
);
  import ued_pkg::*;

  // cells[k] holds row entry k+1, entry 0 lives in dp0
  logic [DIST_W-1:0] cells [MAX_CHARS];
  logic [DIST_W-1:0] dp0;
  logic [DIST_W-1:0] diag;
  logic [DIST_W-1:0] left;

  logic [DIST_W-1:0] up, m, v, base, base_inc;

  always_comb begin
    up = cells[ctrl.idx];
    m  = (up < left) ? up : left;
    if (diag < m) begin
      m = diag;
    end
    v        = (qchar == key) ? diag : m + DIST_W'(1);
    base     = ctrl.init ? '0 : dp0;
    base_inc = base + DIST_W'(1);
    rd_dist  = rd_zero ? dp0 : up;
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      for (int k = 0; k < MAX_CHARS; k++) begin
        cells[k] <= DIST_W'(k + 1);
      end
    end
    if (ctrl.setup) begin
      diag <= base;
      left <= base_inc;
      dp0  <= base_inc;
    end else if (ctrl.init) begin
      dp0 <= '0;
    end
    if (ctrl.step) begin
      cells[ctrl.idx] <= v;
      diag            <= up;
      left            <= v;
    end
  end

endmodule

// ===== hdl/utf8_edit_distance.sv =====
// ----------------------------------------------------------------------------
// utf8_edit_distance
// character-wise levenshtein distance of a streamed candidate to a stored query
// ----------------------------------------------------------------------------
// One byte is taken per word when start is high and busy is low. A byte that
// does not complete a candidate character leaves busy low. A completed
// candidate character within the limit sweeps the row through the single
// cell update unit, one stored query character per cycle, so busy stays
// high until all query characters (up to 32) are swept. A candidate's last
// byte reads the final cell in the finish state, then done pulses for exactly
// one cycle with distance and overflow; the receiver must take the word then.
// Query bytes and query characters never raise busy and give no word out.
module utf8_edit_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ued_pkg::in_word_t  data,
  output logic               busy,
  output logic               done,
  output ued_pkg::out_word_t result
);
  import ued_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SWEEP  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t            state;
  logic              word_open;
  logic              word_kind;
  logic [CNT_W-1:0]  query_count;
  logic [CNT_W-1:0]  candidate_count;
  logic              trunc_flag;
  logic              cand_trunc;
  logic              eow_pend;
  logic [ADDR_W-1:0] pos;
  key_t              key;

  logic              accept, opening, kind;
  logic [CNT_W-1:0]  qcnt_eff, ccnt_eff;
  logic              trunc_eff, ctrunc_eff;
  logic              cand_fin, qry_fin, setup, mem_we, sweep_last;
  logic [ADDR_W-1:0] raddr;
  char_evt_t         evt;
  dp_ctrl_t          dp_ctrl;
  key_t              qchar;
  logic [DIST_W-1:0] rd_dist;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    opening    = !word_open;
    kind       = opening ? data.command : word_kind;
    qcnt_eff   = (opening && !data.command) ? '0 : query_count;
    trunc_eff  = (opening && !data.command) ? 1'b0 : trunc_flag;
    ccnt_eff   = (opening && data.command) ? '0 : candidate_count;
    ctrunc_eff = (opening && data.command) ? 1'b0 : cand_trunc;
    cand_fin   = evt.done && kind;
    qry_fin    = evt.done && !kind;
    setup      = cand_fin && (ccnt_eff < CNT_W'(MAX_CHARS));
    mem_we     = qry_fin && (qcnt_eff < CNT_W'(MAX_CHARS));
    sweep_last = (CNT_W'(pos) + CNT_W'(1)) == query_count;
    raddr      = (state == S_SWEEP) ? pos + ADDR_W'(1) : '0;

    dp_ctrl.init  = accept && opening && data.command;
    dp_ctrl.setup = setup;
    dp_ctrl.step  = (state == S_SWEEP);
    // the finish cycle reuses the cell read port for the last query cell
    dp_ctrl.idx   = (state == S_FINISH) ? ADDR_W'(query_count - CNT_W'(1)) : pos;
  end

  ued_char_asm u_char_asm (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .opening (opening),
    .in_byte (data.in_byte),
    .eow     (data.end_of_word),
    .evt     (evt)
  );

  ued_query_mem u_query_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (qcnt_eff[ADDR_W-1:0]),
    .wdata (evt.key),
    .raddr (raddr),
    .rdata (qchar)
  );

  ued_dp_row u_dp_row (
    .clk     (clk),
    .ctrl    (dp_ctrl),
    .key     (key),
    .qchar   (qchar),
    .rd_zero (query_count == '0),
    .rd_dist (rd_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      word_open       <= 1'b0;
      word_kind       <= 1'b0;
      query_count     <= '0;
      candidate_count <= '0;
      trunc_flag      <= 1'b0;
      cand_trunc      <= 1'b0;
      eow_pend        <= 1'b0;
      pos             <= '0;
      done            <= 1'b0;
    end else begin
      done <= (state == S_FINISH);
      case (state)
        S_IDLE: begin
          if (accept) begin
            word_open       <= !data.end_of_word;
            word_kind       <= kind;
            query_count     <= mem_we ? qcnt_eff + CNT_W'(1) : qcnt_eff;
            trunc_flag      <= trunc_eff || (qry_fin && !mem_we);
            candidate_count <= setup ? ccnt_eff + CNT_W'(1) : ccnt_eff;
            cand_trunc      <= ctrunc_eff || (cand_fin && !setup);
            eow_pend        <= data.end_of_word && kind;
            pos             <= '0;
            if (setup && (query_count != '0)) begin
              state <= S_SWEEP;
            end else if (data.end_of_word && kind) begin
              state <= S_FINISH;
            end
          end
        end
        S_SWEEP: begin
          pos <= pos + ADDR_W'(1);
          if (sweep_last) begin
            state <= eow_pend ? S_FINISH : S_IDLE;
          end
        end
        S_FINISH: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && evt.done) begin
      key <= evt.key;
    end
    if (state == S_FINISH) begin
      result.distance <= rd_dist;
      result.overflow <= trunc_flag || cand_trunc;
    end
  end

endmodule

// ===== hdl/ued_checker.sv =====
// ----------------------------------------------------------------------------
// ued_checker
// port-level checks of the edit distance block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ued_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input ued_pkg::in_word_t  data,
  input logic               busy,
  input logic               done,
  input ued_pkg::out_word_t result
);
  import ued_pkg::*;

  // a result shows up only once the block is free again
  `UED_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  // result strobe lasts a single cycle
  `UED_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  // a byte that does not end a word never yields a word in the next cycle
  `UED_ASSERT_NEXT(a_no_early_done, clk, rst,
    start && !busy && !data.end_of_word, !done)
  // distance cannot exceed the character limit
  `UED_ASSERT_IMPL(a_dist_range, clk, rst, done,
    result.distance <= DIST_W'(MAX_CHARS))
  // busy only rises after an accepted byte
  `UED_ASSERT_IMPL(a_busy_cause, clk, rst, $rose(busy), $past(start))

endmodule

bind utf8_edit_distance ued_checker u_ued_checker (.*);

// ===== tb/sv/utf8_edit_distance_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_edit_distance_tb
// self-checking bench for the character-wise edit distance block
// ----------------------------------------------------------------------------
// Streams query and candidate text as utf-8 bytes, predicts every distance
// and overflow flag in a scoreboard and checks each done pulse against the
// oldest prediction. Text is built from a small table of random characters
// so that matches happen, mixed with mutated copies of the query, long text
// that gets truncated, characters cut short, stray commands and raw noise.
// ----------------------------------------------------------------------------
module utf8_edit_distance_tb;
  import ued_pkg::*;

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_CAND  = 1'b1;
  localparam int   DRAIN_CYCLES = MAX_CHARS + 8;
  localparam int   GLYPHS = 12;

  typedef logic [7:0] byte_q_t[$];
  typedef enum {CMD_KEEP, CMD_STRAY, CMD_FLIP} cmd_mix_t;

  class edit_distance_predictor;
    logic [KEY_W-1:0] query_key[MAX_CHARS];
    int unsigned      query_len;
    int unsigned      row[MAX_CHARS+1];
    logic [ASM_W-1:0] glyph_bits;
    int unsigned      glyph_bytes;
    int unsigned      glyph_left;
    int unsigned      cand_len;
    bit               in_text;
    bit               is_cand;
    bit               query_cut;
    bit               cand_cut;
    out_word_t        expected_q[$];
    int               errors;

    function new();
      foreach (query_key[i]) query_key[i] = '0;
      foreach (row[i]) row[i] = 0;
      query_len   = 0;
      glyph_bits  = '0;
      glyph_bytes = 0;
      glyph_left  = 0;
      cand_len    = 0;
      in_text     = 0;
      is_cand     = 0;
      query_cut   = 0;
      cand_cut    = 0;
      errors      = 0;
    endfunction

    // one byte plus one per set bit below bit 7, up to the first clear one
    function int unsigned lead_run(logic [7:0] b);
      int unsigned n;
      n = 1;
      if (b[7]) begin
        for (int k = 6; k >= 1; k--) begin
          if (!b[k]) break;
          n++;
        end
      end
      return n;
    endfunction

    function void add_char(logic [KEY_W-1:0] key);
      int unsigned diag, left, up, v;
      if (!is_cand) begin
        if (query_len < MAX_CHARS) begin
          query_key[query_len] = key;
          query_len++;
        end else begin
          query_cut = 1;
        end
        return;
      end
      if (cand_len >= MAX_CHARS) begin
        cand_cut = 1;
        return;
      end
      diag   = row[0];
      left   = diag + 1;
      row[0] = left;
      for (int i = 1; i <= query_len; i++) begin
        up = row[i];
        if (query_key[i-1] == key) begin
          v = diag;
        end else begin
          v = (up < left) ? up : left;
          if (diag < v) v = diag;
          v = v + 1;
        end
        row[i] = v;
        diag   = up;
        left   = v;
      end
      cand_len++;
    endfunction

    function void take_byte(in_word_t w);
      int unsigned d;
      out_word_t   want;
      if (!in_text) begin
        in_text     = 1;
        is_cand     = (w.command == CMD_CAND);
        glyph_bits  = '0;
        glyph_bytes = 0;
        glyph_left  = 0;
        if (is_cand) begin
          cand_len = 0;
          cand_cut = 0;
          for (int i = 0; i <= MAX_CHARS; i++) row[i] = i;
        end else begin
          query_len = 0;
          query_cut = 0;
        end
      end
      if (glyph_left == 0) begin
        glyph_bits  = ASM_W'(w.in_byte);
        glyph_bytes = 1;
        glyph_left  = lead_run(w.in_byte) - 1;
      end else begin
        glyph_bits  = glyph_bits | (ASM_W'(w.in_byte) << (8 * glyph_bytes));
        glyph_bytes++;
        glyph_left--;
      end
      if (glyph_left == 0 || w.end_of_word) begin
        add_char({GRP_W'(glyph_bytes), glyph_bits});
        glyph_bits  = '0;
        glyph_bytes = 0;
        glyph_left  = 0;
      end
      if (w.end_of_word) begin
        in_text = 0;
        if (is_cand) begin
          d = row[query_len];
          if (d > 63) d = 63;
          want.distance = DIST_W'(d);
          want.overflow = query_cut || cand_cut;
          expected_q.push_back(want);
        end
      end
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_distance(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("distance %0d with nothing expected", got.distance));
        return;
      end
      want = expected_q.pop_front();
      if (got.distance !== want.distance)
        report($sformatf("distance %0d, expected %0d", got.distance, want.distance));
      if (got.overflow !== want.overflow)
        report($sformatf("overflow %0b, expected %0b", got.overflow, want.overflow));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  in_word_t   data;
  logic       busy;
  logic       done;
  out_word_t  result;

  edit_distance_predictor board = new();

  logic [ASM_W-1:0] glyph_val[GLYPHS];
  int               glyph_len[GLYPHS];
  int               cur_query[$];
  int               send_idle;
  int               sent;

  utf8_edit_distance uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .data   (data),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_distance(result);
  end

  task automatic send_byte(in_word_t w);
    if ($urandom_range(99) < send_idle) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    start <= 1'b1;
    data  <= w;
    do @(posedge clk); while (busy);
    board.take_byte(w);
    sent++;
  endtask

  task automatic send_bytes(logic cmd, byte_q_t bytes, cmd_mix_t mix);
    in_word_t w;
    for (int i = 0; i < bytes.size(); i++) begin
      w.command = cmd;
      if (i > 0 && mix == CMD_STRAY) w.command = 1'($urandom_range(1));
      if (i > 0 && mix == CMD_FLIP) w.command = !cmd;
      w.in_byte     = bytes[i];
      w.end_of_word = (i == bytes.size() - 1);
      send_byte(w);
    end
  endtask

  // hold the sender until every distance is back and the sweep has settled
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (board.expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic make_glyphs();
    int          n;
    logic [7:0]  lead;
    for (int g = 0; g < GLYPHS; g++) begin
      n = ($urandom_range(1) == 0) ? 1 : $urandom_range(2, 7);
      if (n == 1) begin
        lead = ($urandom_range(1) == 0) ? 8'($urandom_range(127))
                                        : 8'($urandom_range(128, 191));
      end else if (n == 7) begin
        lead = 8'hFE | 8'($urandom_range(1));
      end else begin
        lead = (8'hFF << (8 - n)) | 8'($urandom_range((1 << (7 - n)) - 1));
      end
      glyph_val[g] = ASM_W'(lead);
      for (int k = 1; k < n; k++)
        glyph_val[g][8*k +: 8] = 8'($urandom_range(255));
      glyph_len[g] = n;
    end
  endtask

  task automatic send_glyphs(logic cmd, int chars[$], bit cut, cmd_mix_t mix);
    byte_q_t bytes;
    int      last;
    foreach (chars[i]) begin
      for (int k = 0; k < glyph_len[chars[i]]; k++)
        bytes.push_back(glyph_val[chars[i]][8*k +: 8]);
    end
    last = glyph_len[chars[chars.size()-1]];
    if (cut && last > 1) begin
      repeat ($urandom_range(1, last - 1)) void'(bytes.pop_back());
    end
    send_bytes(cmd, bytes, mix);
  endtask

  task automatic random_text();
    int       chars[$];
    byte_q_t  noise;
    int       pick, n, pos;
    logic     cmd;
    cmd_mix_t mix;
    cmd  = ($urandom_range(99) < 22) ? CMD_QUERY : CMD_CAND;
    mix  = ($urandom_range(99) < 10) ? CMD_STRAY : CMD_KEEP;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 12)) noise.push_back(8'($urandom_range(255)));
      send_bytes(cmd, noise, mix);
    end else begin
      if (cmd == CMD_CAND && pick < 70 && cur_query.size() != 0) begin
        chars = cur_query;
        repeat ($urandom_range(3)) begin
          pos = $urandom_range(chars.size() - 1);
          case ($urandom_range(2))
            0: chars.insert(pos, $urandom_range(GLYPHS - 1));
            1: if (chars.size() > 1) chars.delete(pos);
            default: chars[pos] = $urandom_range(GLYPHS - 1);
          endcase
        end
      end else begin
        n = (pick < 88) ? $urandom_range(1, 8) : $urandom_range(28, 40);
        repeat (n) chars.push_back($urandom_range(GLYPHS - 1));
      end
      if (cmd == CMD_QUERY) cur_query = chars;
      send_glyphs(cmd, chars, $urandom_range(99) < 10, mix);
    end
    if ($urandom_range(99) < 2) wait_drained();
  endtask

  initial begin
    byte_q_t q;
    rst   <= 1'b1;
    start <= 1'b0;
    data  <= '0;
    send_idle = 0;
    sent      = 0;
    make_glyphs();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // no query stored yet: distance is the candidate length
    q = {8'h00};
    send_bytes(CMD_CAND, q, CMD_KEEP);
    // ascii, a lone 10xxxxxx byte and a two-byte character
    q = {8'h7F, 8'h80, 8'hC3, 8'hA9};
    send_bytes(CMD_QUERY, q, CMD_KEEP);
    // command toggles after the first byte and must be ignored
    send_bytes(CMD_CAND, q, CMD_FLIP);
    // seven-byte group ended early
    q = {8'hFE, 8'h01, 8'h02};
    send_bytes(CMD_CAND, q, CMD_KEEP);
    q = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_bytes(CMD_QUERY, q, CMD_KEEP);
    send_bytes(CMD_CAND, q, CMD_KEEP);
    wait_drained();

    send_idle = 8;
    while (sent < 450) random_text();
    wait_drained();
    send_idle = 52;
    while (sent < 660) random_text();
    send_idle = 0;
    while (sent < 875) random_text();
    wait_drained();

    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
